FILE: hdl/pfvc_pkg.sv
// ----------------------------------------------------------------------------
// pfvc_pkg
// Shared types, constants and the arctangent table of the goal-point
// velocity controller.
// ----------------------------------------------------------------------------
package pfvc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

	localparam int PRE_SHIFT = 8;
	// x/y datapath: Q.20, grows by the cordic gain after the quadrant swap
	localparam int XW = 28;
	// angle datapath: Q.24 radians, covers +-pi
	localparam int ZW = 28;

	localparam logic signed [ZW-1:0] HALF_PI_Q24  = ZW'(32'sd26353589);
	localparam logic signed [17:0]   INV_GAIN_Q16 = 18'sd39797;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINEAR_GAIN       = 3'd0,
		REG_ANGULAR_GAIN      = 3'd1,
		REG_FOLLOW_DISTANCE   = 3'd2,
		REG_LINEAR_LIMIT      = 3'd3,
		REG_ANGULAR_LIMIT     = 3'd4,
		REG_LINEAR_DEAD_BAND  = 3'd5,
		REG_ANGULAR_DEAD_BAND = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] linear_gain;
		logic [15:0] angular_gain;
		logic [14:0] follow_distance;
		logic [14:0] linear_limit;
		logic [14:0] angular_limit;
		logic [14:0] linear_dead_band;
		logic [14:0] angular_dead_band;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 origin;
		logic                 tgt_valid;
	} cordic_beat_t;

	function automatic logic signed [ZW-1:0] atan_q24(input int unsigned idx);
		logic signed [31:0] a;
		case (idx)
			0: a = 32'sd13176795;
			1: a = 32'sd7778716;
			2: a = 32'sd4110060;
			3: a = 32'sd2086331;
			4: a = 32'sd1047214;
			5: a = 32'sd524117;
			6: a = 32'sd262123;
			7: a = 32'sd131069;
			8: a = 32'sd65536;
			9: a = 32'sd32768;
			10: a = 32'sd16384;
			11: a = 32'sd8192;
			12: a = 32'sd4096;
			13: a = 32'sd2048;
			14: a = 32'sd1024;
			15: a = 32'sd512;
			16: a = 32'sd256;
			17: a = 32'sd128;
			18: a = 32'sd64;
			19: a = 32'sd32;
			20: a = 32'sd16;
			21: a = 32'sd8;
			22: a = 32'sd4;
			23: a = 32'sd2;
			default: a = 32'sd0;
		endcase
		return ZW'(a);
	endfunction

endpackage

FILE: hdl/pfvc_if.sv
// ----------------------------------------------------------------------------
// pfvc_if
// Valid/ready channels of the goal-point velocity controller: goal points in,
// velocity commands out, register writes.
// ----------------------------------------------------------------------------
interface pfvc_target_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic               target_valid;

	modport source (output valid, output target_x, output target_y, output target_valid,
		input ready);
	modport sink (input valid, input target_x, input target_y, input target_valid,
		output ready);
endinterface

interface pfvc_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] linear_speed;
	logic signed [15:0] angular_rate;

	modport source (output valid, output linear_speed, output angular_rate, input ready);
	modport sink (input valid, input linear_speed, input angular_rate, output ready);
endinterface

interface pfvc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pfvc_pkg::CFG_IDX_W-1:0]   index;
	logic [pfvc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pfvc_cfg.sv
// ----------------------------------------------------------------------------
// pfvc_cfg
// Register file for gains, follow distance, limits and dead bands.
// ----------------------------------------------------------------------------
module pfvc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	pfvc_cfg_if.sink            cfg,
	output pfvc_pkg::cfg_regs_t regs
);

	pfvc_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.linear_gain       <= 16'd12288;
			regs_q.angular_gain      <= 16'd3277;
			regs_q.follow_distance   <= 15'd2048;
			regs_q.linear_limit      <= 15'd3277;
			regs_q.angular_limit     <= 15'd4915;
			regs_q.linear_dead_band  <= 15'd410;
			regs_q.angular_dead_band <= 15'd410;
		end else if (cfg.valid) begin
			case (pfvc_pkg::cfg_idx_t'(cfg.index))
				pfvc_pkg::REG_LINEAR_GAIN:       regs_q.linear_gain <= cfg.data;
				pfvc_pkg::REG_ANGULAR_GAIN:      regs_q.angular_gain <= cfg.data;
				pfvc_pkg::REG_FOLLOW_DISTANCE:   regs_q.follow_distance <= cfg.data[14:0];
				pfvc_pkg::REG_LINEAR_LIMIT:      regs_q.linear_limit <= cfg.data[14:0];
				pfvc_pkg::REG_ANGULAR_LIMIT:     regs_q.angular_limit <= cfg.data[14:0];
				pfvc_pkg::REG_LINEAR_DEAD_BAND:  regs_q.linear_dead_band <= cfg.data[14:0];
				pfvc_pkg::REG_ANGULAR_DEAD_BAND: regs_q.angular_dead_band <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/pfvc_cordic.sv
// ----------------------------------------------------------------------------
// pfvc_cordic
// Pipelined vectoring cordic: quadrant swap stage, then one register stage
// per micro-rotation. Bubbles collapse, a stall holds each stage.
// ----------------------------------------------------------------------------
module pfvc_cordic (
	input  logic                   clk,
	input  logic                   arst_n,
	pfvc_target_if.sink            target,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pfvc_pkg::cordic_beat_t out_beat
);

	localparam int N = pfvc_pkg::CORDIC_ITERS;

	pfvc_pkg::cordic_beat_t beat_s [0:N];
	logic                   vld_s  [0:N];
	logic                   en     [0:N+1];

	pfvc_pkg::cordic_beat_t pre_beat;
	logic signed [pfvc_pkg::XW-1:0] x_in;
	logic signed [pfvc_pkg::XW-1:0] y_in;

	always_comb begin
		en[N+1] = out_ready;
		for (int k = N; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign target.ready = en[0];
	assign out_valid    = vld_s[N];
	assign out_beat     = beat_s[N];

	// inputs up to Q.20, then swap into the right half plane
	assign x_in = pfvc_pkg::XW'(target.target_x) <<< pfvc_pkg::PRE_SHIFT;
	assign y_in = pfvc_pkg::XW'(target.target_y) <<< pfvc_pkg::PRE_SHIFT;

	always_comb begin
		pre_beat.origin    = (target.target_x == 16'sd0) && (target.target_y == 16'sd0);
		pre_beat.tgt_valid = target.target_valid;
		pre_beat.x         = x_in;
		pre_beat.y         = y_in;
		pre_beat.z         = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				pre_beat.x = y_in;
				pre_beat.y = -x_in;
				pre_beat.z = pfvc_pkg::HALF_PI_Q24;
			end else begin
				pre_beat.x = -y_in;
				pre_beat.y = x_in;
				pre_beat.z = -pfvc_pkg::HALF_PI_Q24;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en[0]) begin
			vld_s[0] <= target.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			beat_s[0] <= pre_beat;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		pfvc_pkg::cordic_beat_t nxt;
		logic signed [pfvc_pkg::XW-1:0] dx;
		logic signed [pfvc_pkg::XW-1:0] dy;

		assign dx = beat_s[i].x >>> i;
		assign dy = beat_s[i].y >>> i;

		always_comb begin
			nxt = beat_s[i];
			if (beat_s[i].y >= 0) begin
				nxt.x = beat_s[i].x + dy;
				nxt.y = beat_s[i].y - dx;
				nxt.z = beat_s[i].z + pfvc_pkg::atan_q24(i);
			end else begin
				nxt.x = beat_s[i].x - dy;
				nxt.y = beat_s[i].y + dx;
				nxt.z = beat_s[i].z - pfvc_pkg::atan_q24(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en[i+1]) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				beat_s[i+1] <= nxt;
			end
		end
	end

endmodule

FILE: hdl/pfvc_scale.sv
// ----------------------------------------------------------------------------
// pfvc_scale
// Turns the cordic result into commands: gain correction of the distance,
// bearing rounding, gain products, clamp, dead band. Five register stages,
// the last one is the output register.
// ----------------------------------------------------------------------------
module pfvc_scale (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfvc_pkg::cfg_regs_t    regs,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pfvc_pkg::cordic_beat_t in_beat,
	pfvc_cmd_if.source             command
);

	localparam int PW = pfvc_pkg::XW + 18;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	// stage 1: distance product, rounded bearing
	logic signed [PW-1:0] dprod_s1;
	logic signed [15:0]   bear_s1;
	logic                 origin_s1, tv_s1;
	// stage 2: distance error
	logic signed [18:0]   err_s2;
	logic signed [15:0]   bear_s2;
	logic                 tv_s2;
	// stage 3: gain products
	logic signed [35:0]   vprod_s3;
	logic signed [32:0]   wprod_s3;
	logic                 tv_s3;
	// stage 4: rounded and clamped
	logic signed [15:0]   vclamp_s4;
	logic signed [15:0]   wclamp_s4;
	logic                 tv_s4;
	// stage 5: output
	logic signed [15:0]   lin_s5;
	logic signed [15:0]   ang_s5;

	logic signed [pfvc_pkg::ZW-1:0] zsum;
	logic signed [pfvc_pkg::ZW-1:0] zsh;
	logic signed [PW-1:0]           dsum;
	logic [16:0]                    distance;
	logic signed [35:0]             vr, vlim;
	logic signed [32:0]             wr, wlim;
	logic signed [15:0]             vnext, wnext;
	logic [15:0]                    vmag, wmag;

	assign en5 = command.ready || !vld_s5;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	assign command.valid        = vld_s5;
	assign command.linear_speed = lin_s5;
	assign command.angular_rate = ang_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	assign zsum = in_beat.z + pfvc_pkg::ZW'(2048);
	assign zsh  = zsum >>> 12;

	always_ff @(posedge clk) begin
		if (en1) begin
			dprod_s1  <= PW'(in_beat.x) * PW'(pfvc_pkg::INV_GAIN_Q16);
			bear_s1   <= zsh[15:0];
			origin_s1 <= in_beat.origin;
			tv_s1     <= in_beat.tgt_valid;
		end
	end

	// distance is never negative once the vector sits in the right half plane
	assign dsum     = dprod_s1 + (PW'(1) <<< 23);
	assign distance = origin_s1 ? 17'd0 : dsum[40:24];

	always_ff @(posedge clk) begin
		if (en2) begin
			err_s2  <= $signed({2'b00, distance}) - $signed({4'b0000, regs.follow_distance});
			bear_s2 <= origin_s1 ? 16'sd0 : bear_s1;
			tv_s2   <= tv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			vprod_s3 <= 36'($signed({1'b0, regs.linear_gain})) * 36'(err_s2);
			wprod_s3 <= 33'($signed({1'b0, regs.angular_gain})) * 33'(bear_s2);
			tv_s3    <= tv_s2;
		end
	end

	assign vr   = (vprod_s3 + 36'sd2048) >>> 12;
	assign wr   = (wprod_s3 + 33'sd2048) >>> 12;
	assign vlim = $signed({21'd0, regs.linear_limit});
	assign wlim = $signed({18'd0, regs.angular_limit});

	always_comb begin
		if (vr > vlim) begin
			vnext = vlim[15:0];
		end else if (vr < -vlim) begin
			vnext = -vlim[15:0];
		end else begin
			vnext = vr[15:0];
		end
		if (wr > wlim) begin
			wnext = wlim[15:0];
		end else if (wr < -wlim) begin
			wnext = -wlim[15:0];
		end else begin
			wnext = wr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			vclamp_s4 <= vnext;
			wclamp_s4 <= wnext;
			tv_s4     <= tv_s3;
		end
	end

	assign vmag = vclamp_s4[15] ? 16'(-vclamp_s4) : 16'(vclamp_s4);
	assign wmag = wclamp_s4[15] ? 16'(-wclamp_s4) : 16'(wclamp_s4);

	always_ff @(posedge clk) begin
		if (en5) begin
			if (!tv_s4 || vmag < {1'b0, regs.linear_dead_band}) begin
				lin_s5 <= 16'sd0;
			end else begin
				lin_s5 <= vclamp_s4;
			end
			if (!tv_s4 || wmag < {1'b0, regs.angular_dead_band}) begin
				ang_s5 <= 16'sd0;
			end else begin
				ang_s5 <= wclamp_s4;
			end
		end
	end

endmodule

FILE: hdl/point_follow_velocity_controller.sv
// ----------------------------------------------------------------------------
// Pipeline from accepted goal point to command valid: swap stage, one stage per
// micro-rotation, five scaling stages ending in the output register.
// Throughput: one goal point per cycle while the output does not stall;
// empty stages fill while the output stalls.
// Reset: pipeline empties, registers return to their defaults.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// point_follow_velocity_controller
// Goal-point pursuit: distance and bearing by cordic, proportional linear
// speed and turn rate with clamp and dead band.
// ----------------------------------------------------------------------------
module point_follow_velocity_controller (
	input  logic        clk,
	input  logic        arst_n,
	pfvc_target_if.sink target,
	pfvc_cmd_if.source  command,
	pfvc_cfg_if.sink    cfg
);

	pfvc_pkg::cfg_regs_t    regs;
	pfvc_pkg::cordic_beat_t cordic_beat;
	logic                   cordic_valid;
	logic                   cordic_ready;

	pfvc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pfvc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target),
		.out_valid (cordic_valid),
		.out_ready (cordic_ready),
		.out_beat  (cordic_beat)
	);

	pfvc_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.in_valid (cordic_valid),
		.in_ready (cordic_ready),
		.in_beat  (cordic_beat),
		.command  (command)
	);

endmodule

FILE: tb/sv/tb_point_follow_velocity_controller.sv
// ----------------------------------------------------------------------------
// tb_point_follow_velocity_controller
// Streams goal points into the pursuit controller under several register
// settings and checks every velocity command against a cycle-free software
// model of the cordic, gain, clamp and dead band arithmetic.
// ----------------------------------------------------------------------------
module tb_point_follow_velocity_controller;

	import pfvc_pkg::*;

	localparam int  ROTATIONS   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int  PIPE_DEPTH  = ROTATIONS + 6;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  SHOWN_MAX   = 10;
	localparam longint QUARTER_TURN_Q24 = 64'sd26353589;
	localparam longint CORDIC_SCALE_Q16 = 64'sd39797;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_UNUSED = 3'd7;

	localparam longint ATAN_Q24 [24] = '{
		64'sd13176795, 64'sd7778716, 64'sd4110060, 64'sd2086331, 64'sd1047214,
		64'sd524117, 64'sd262123, 64'sd131069, 64'sd65536, 64'sd32768,
		64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048, 64'sd1024, 64'sd512,
		64'sd256, 64'sd128, 64'sd64, 64'sd32, 64'sd16, 64'sd8, 64'sd4, 64'sd2
	};

	typedef struct {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic               target_valid;
	} goal_t;

	typedef struct {
		logic signed [15:0] linear_speed;
		logic signed [15:0] angular_rate;
	} velocity_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	pfvc_target_if target_ch();
	pfvc_cmd_if    command_ch();
	pfvc_cfg_if    cfg_ch();

	point_follow_velocity_controller DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (target_ch),
		.command (command_ch),
		.cfg     (cfg_ch)
	);

	goal_t      goal_q[$];
	velocity_t  velocity_expected_q[$];
	reg_write_t reg_write_q[$];
	cfg_regs_t  regs_shadow;
	bit         steady;
	int         mismatches;
	int         cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 14);
	endfunction

	function automatic longint clamp_and_gate(longint cmd, longint lim, longint band);
		longint mag;
		if (cmd > lim)
			cmd = lim;
		else if (cmd < -lim)
			cmd = -lim;
		mag = (cmd < 0) ? -cmd : cmd;
		if (mag < band)
			cmd = 0;
		return cmd;
	endfunction

	function automatic velocity_t velocity_from_goal(goal_t g, cfg_regs_t r);
		longint    x, y, z, t, dx, dy, distance, bear, v, w;
		velocity_t c;
		c.linear_speed = '0;
		c.angular_rate = '0;
		if (!g.target_valid)
			return c;
		distance = 0;
		bear = 0;
		if (g.target_x != 0 || g.target_y != 0) begin
			x = longint'(g.target_x) * 256;
			y = longint'(g.target_y) * 256;
			z = 0;
			// goal behind: pre-rotate by a quarter turn toward the right half plane
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y;
					y = -t;
					z = QUARTER_TURN_Q24;
				end else begin
					x = -y;
					y = t;
					z = -QUARTER_TURN_Q24;
				end
			end
			for (int i = 0; i < ROTATIONS; i++) begin
				dx = x >>> i;
				dy = y >>> i;
				if (y >= 0) begin
					x = x + dy;
					y = y - dx;
					z = z + ATAN_Q24[i];
				end else begin
					x = x - dy;
					y = y + dx;
					z = z - ATAN_Q24[i];
				end
			end
			distance = (x * CORDIC_SCALE_Q16 + (64'sd1 <<< 23)) >>> 24;
			bear = (z + 2048) >>> 12;
		end
		v = (longint'(r.linear_gain) * (distance - longint'(r.follow_distance)) + 2048) >>> 12;
		w = (longint'(r.angular_gain) * bear + 2048) >>> 12;
		v = clamp_and_gate(v, longint'(r.linear_limit), longint'(r.linear_dead_band));
		w = clamp_and_gate(w, longint'(r.angular_limit), longint'(r.angular_dead_band));
		c.linear_speed = v[15:0];
		c.angular_rate = w[15:0];
		return c;
	endfunction

	task automatic report_mismatch(string what, int expected_val, int actual_val);
		mismatches++;
		if (mismatches <= SHOWN_MAX)
			$display("mismatch %s: expected %0d actual %0d", what, expected_val, actual_val);
	endtask

	// goal point driver
	always @(posedge clk or negedge arst_n) begin
		goal_t g;
		if (!arst_n) begin
			target_ch.valid <= 1'b0;
			target_ch.target_x <= '0;
			target_ch.target_y <= '0;
			target_ch.target_valid <= 1'b0;
		end else begin
			if (target_ch.valid && target_ch.ready) begin
				g.target_x = target_ch.target_x;
				g.target_y = target_ch.target_y;
				g.target_valid = target_ch.target_valid;
				velocity_expected_q.push_back(velocity_from_goal(g, regs_shadow));
			end
			if (!target_ch.valid || target_ch.ready) begin
				if (goal_q.size() != 0 && !take_break()) begin
					g = goal_q.pop_front();
					target_ch.valid <= 1'b1;
					target_ch.target_x <= g.target_x;
					target_ch.target_y <= g.target_y;
					target_ch.target_valid <= g.target_valid;
				end else begin
					target_ch.valid <= 1'b0;
				end
			end
		end
	end

	// register write driver, keeps the shadow copy in step with accepted beats
	always @(posedge clk or negedge arst_n) begin
		reg_write_t wr;
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= '0;
			cfg_ch.data <= '0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_LINEAR_GAIN:       regs_shadow.linear_gain = cfg_ch.data;
					REG_ANGULAR_GAIN:      regs_shadow.angular_gain = cfg_ch.data;
					REG_FOLLOW_DISTANCE:   regs_shadow.follow_distance = cfg_ch.data[14:0];
					REG_LINEAR_LIMIT:      regs_shadow.linear_limit = cfg_ch.data[14:0];
					REG_ANGULAR_LIMIT:     regs_shadow.angular_limit = cfg_ch.data[14:0];
					REG_LINEAR_DEAD_BAND:  regs_shadow.linear_dead_band = cfg_ch.data[14:0];
					REG_ANGULAR_DEAD_BAND: regs_shadow.angular_dead_band = cfg_ch.data[14:0];
					default: ;
				endcase
			end
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (reg_write_q.size() != 0 && !take_break()) begin
					wr = reg_write_q.pop_front();
					cfg_ch.valid <= 1'b1;
					cfg_ch.index <= wr.index;
					cfg_ch.data <= wr.data;
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// command monitor
	always @(posedge clk or negedge arst_n) begin
		velocity_t want;
		if (!arst_n) begin
			command_ch.ready <= 1'b0;
		end else begin
			if (command_ch.valid && command_ch.ready) begin
				if (velocity_expected_q.size() == 0) begin
					report_mismatch("unexpected command beat, linear_speed",
						0, command_ch.linear_speed);
				end else begin
					want = velocity_expected_q.pop_front();
					if (command_ch.linear_speed !== want.linear_speed)
						report_mismatch("linear_speed", want.linear_speed,
							command_ch.linear_speed);
					if (command_ch.angular_rate !== want.angular_rate)
						report_mismatch("angular_rate", want.angular_rate,
							command_ch.angular_rate);
				end
			end
			command_ch.ready <= !take_break();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_goal(int x, int y, bit ok);
		goal_t g;
		g.target_x = 16'(x);
		g.target_y = 16'(y);
		g.target_valid = ok;
		goal_q.push_back(g);
	endtask

	function automatic goal_t random_goal();
		goal_t       g;
		int unsigned pick;
		pick = $urandom_range(99);
		g.target_x = 16'($urandom);
		g.target_y = 16'($urandom);
		g.target_valid = ($urandom_range(99) >= 3);
		if (pick < 45) begin
			// spread magnitudes over many scales
			g.target_x = g.target_x >>> $urandom_range(12);
			g.target_y = g.target_y >>> $urandom_range(12);
		end else if (pick < 55) begin
			if (pick[0])
				g.target_x = '0;
			else
				g.target_y = '0;
		end else if (pick < 62) begin
			g.target_x = 16'(int'($urandom_range(6)) - 3);
			g.target_y = 16'(int'($urandom_range(6)) - 3);
		end else if (pick < 72) begin
			g.target_valid = 1'b0;
		end
		return g;
	endfunction

	task automatic write_all_regs(logic [15:0] lin_gain, logic [15:0] ang_gain,
		logic [15:0] follow, logic [15:0] lin_lim, logic [15:0] ang_lim,
		logic [15:0] lin_band, logic [15:0] ang_band);
		reg_write_q.push_back({REG_LINEAR_GAIN, lin_gain});
		reg_write_q.push_back({REG_ANGULAR_GAIN, ang_gain});
		reg_write_q.push_back({REG_FOLLOW_DISTANCE, follow});
		reg_write_q.push_back({REG_LINEAR_LIMIT, lin_lim});
		reg_write_q.push_back({REG_ANGULAR_LIMIT, ang_lim});
		reg_write_q.push_back({REG_LINEAR_DEAD_BAND, lin_band});
		reg_write_q.push_back({REG_ANGULAR_DEAD_BAND, ang_band});
		while (reg_write_q.size() != 0 || cfg_ch.valid)
			@(negedge clk);
	endtask

	task automatic run_goals(int count);
		repeat (count)
			goal_q.push_back(random_goal());
		while (goal_q.size() != 0 || target_ch.valid || velocity_expected_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		target_ch.valid = 1'b0;
		target_ch.target_x = '0;
		target_ch.target_y = '0;
		target_ch.target_valid = 1'b0;
		command_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		steady = 1'b0;
		mismatches = 0;
		cycles = 0;
		regs_shadow.linear_gain = 16'd12288;
		regs_shadow.angular_gain = 16'd3277;
		regs_shadow.follow_distance = 15'd2048;
		regs_shadow.linear_limit = 15'd3277;
		regs_shadow.angular_limit = 15'd4915;
		regs_shadow.linear_dead_band = 15'd410;
		regs_shadow.angular_dead_band = 15'd410;
		repeat (10)
			@(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: corners of the input space first
		push_goal(32767, 32767, 1'b1);
		push_goal(-32768, -32768, 1'b1);
		push_goal(32767, -32768, 1'b1);
		push_goal(-32768, 32767, 1'b1);
		push_goal(0, 0, 1'b1);
		push_goal(-4096, 0, 1'b1);
		push_goal(-4096, -1, 1'b1);
		push_goal(-1, 0, 1'b1);
		push_goal(-32768, 0, 1'b1);
		push_goal(4096, 0, 1'b1);
		push_goal(0, 4096, 1'b1);
		push_goal(0, -4096, 1'b1);
		push_goal(0, -32768, 1'b1);
		push_goal(2048, 0, 1'b1);
		push_goal(2200, 0, 1'b1);
		push_goal(1, 1, 1'b1);
		push_goal(-1, -1, 1'b1);
		push_goal(12000, 9000, 1'b0);
		push_goal(-1, -1, 1'b0);
		push_goal(-32768, -32768, 1'b0);
		run_goals(200);

		// typical values, plus a write to an unused index; no idling here
		steady = 1'b1;
		write_all_regs(16'd8192, 16'd4096, 16'd4096, 16'd8192, 16'd12000,
			16'd200, 16'd100);
		reg_write_q.push_back({REG_INDEX_UNUSED, 16'hFFFF});
		while (reg_write_q.size() != 0 || cfg_ch.valid)
			@(negedge clk);
		run_goals(250);
		steady = 1'b0;

		// all but the dead bands at their top, upper data bit must be dropped
		write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		run_goals(200);

		// zero limits force zero commands
		write_all_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_goals(100);

		// dead band wider than the limit
		write_all_regs(16'd12288, 16'd3277, 16'd2048, 16'd1000, 16'd800, 16'd2000, 16'h7FFF);
		run_goals(100);

		repeat (4) begin
			write_all_regs(16'($urandom), 16'($urandom), 16'($urandom_range(32767)),
				16'($urandom_range(32767)), 16'($urandom_range(32767)),
				16'($urandom_range(1000)), 16'($urandom_range(1000)));
			run_goals(150);
		end

		if (mismatches == 0 && velocity_expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pfvc_pkg.sv
hdl/pfvc_if.sv
hdl/pfvc_cfg.sv
hdl/pfvc_cordic.sv
hdl/pfvc_scale.sv
hdl/point_follow_velocity_controller.sv
tb/sv/tb_point_follow_velocity_controller.sv
